// ----- rtl/pte_pkg.sv -----
// Shared types and constants of the property tween engine.
package pte_pkg;

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NODE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] PROP_NONE = 2'd3;

  localparam logic [1:0] EASE_LINEAR = 2'd0;
  localparam logic [1:0] EASE_IN     = 2'd1;
  localparam logic [1:0] EASE_INOUT  = 2'd3;

  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  typedef enum logic [1:0] {
    PW_CLEAR  = 2'd0,
    PW_INPUT  = 2'd1,
    PW_TARGET = 2'd2,
    PW_BLEND  = 2'd3
  } pw_t;

  typedef enum logic [1:0] {
    TW_KEEP = 2'd0,
    TW_UPD  = 2'd1,
    TW_NEW  = 2'd2
  } tws_t;

  typedef struct packed {
    logic [7:0]  node;
    logic [1:0]  prop;
    logic [31:0] from;
    logic [31:0] to;
    logic [23:0] len;
    logic [24:0] el;
    logic [1:0]  curve;
  } tween_t;

  typedef struct packed {
    logic latch;
    logic prop_we;
    pw_t  pw;
    logic clr_one;
    logic prop_re;
    logic tw_re;
    logic tw_we;
    tws_t tws;
    logic load_cur;
    logic div_step;
    logic mul_x;
    logic mul_sq;
    logic mul_cb;
    logic mul_e;
    logic mul_p;
    logic cap_from;
    logic cap_rd;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic done;
  } stat_t;

endpackage

// ----- rtl/pte_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pte_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                    wdata,
  input  logic                            re,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                    rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/pte_ctrl.sv -----
// Controller state machine of the property tween engine.
module pte_ctrl #(
  parameter int NODE_COUNT  = 256,
  parameter int TWEEN_SLOTS = 16,
  parameter int AW          = 10,
  parameter int TI          = 4,
  parameter int CW          = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_opcode,
  input  logic [7:0]        in_node_index,
  input  logic [1:0]        in_property_select,
  input  pte_pkg::stat_t    stat,
  output pte_pkg::cmd_t     cmd,
  output logic [AW-1:0]     clr_addr,
  output logic [TI-1:0]     tw_raddr,
  output logic [TI-1:0]     tw_waddr,
  output logic              busy,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [4:0]        out_active_tweens
);

  localparam int P = NODE_COUNT * 3;

  typedef enum logic [15:0] {
    S_CLEAR  = 16'h0001,
    S_IDLE   = 16'h0002,
    S_DECODE = 16'h0004,
    S_RDAT   = 16'h0008,
    S_FROM   = 16'h0010,
    S_WRD    = 16'h0020,
    S_WEV    = 16'h0040,
    S_DIV    = 16'h0080,
    S_MX     = 16'h0100,
    S_MSQ    = 16'h0200,
    S_MCB    = 16'h0400,
    S_ME     = 16'h0800,
    S_MP     = 16'h1000,
    S_WWR    = 16'h2000,
    S_APPEND = 16'h4000,
    S_DONE   = 16'h8000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] i_r, i_nxt, kept_r, kept_nxt, cnt_r, cnt_nxt;
  logic          found_r, found_nxt;
  logic [3:0]    dcnt_r, dcnt_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [1:0]    op_r;
  logic          bad_r, p3_r;
  logic          more;

  assign more = ({1'b0, i_r} + (CW+1)'(1)) < {1'b0, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      phase_r  <= 2'd0;
      i_r      <= '0;
      kept_r   <= '0;
      cnt_r    <= '0;
      found_r  <= 1'b0;
      dcnt_r   <= 4'd0;
      status_r <= pte_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      phase_r  <= phase_nxt;
      i_r      <= i_nxt;
      kept_r   <= kept_nxt;
      cnt_r    <= cnt_nxt;
      found_r  <= found_nxt;
      dcnt_r   <= dcnt_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_opcode;
      bad_r <= 17'(in_node_index) >= 17'(NODE_COUNT);
      p3_r  <= in_property_select == pte_pkg::PROP_NONE;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    phase_nxt  = phase_r;
    i_nxt      = i_r;
    kept_nxt   = kept_r;
    cnt_nxt    = cnt_r;
    found_nxt  = found_r;
    dcnt_nxt   = dcnt_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.pw     = pte_pkg::PW_CLEAR;
    cmd.tws    = pte_pkg::TW_KEEP;
    unique case (state_r)
      S_CLEAR: begin
        cmd.prop_we = 1'b1;
        cmd.clr_one = phase_r == 2'd0;
        clr_nxt     = clr_r + AW'(1);
        phase_nxt   = (phase_r == 2'd2) ? 2'd0 : phase_r + 2'd1;
        if (clr_r == AW'(P - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        status_nxt = pte_pkg::ST_OK;
        i_nxt      = '0;
        kept_nxt   = '0;
        found_nxt  = 1'b0;
        state_nxt  = S_DONE;
        if (op_r == pte_pkg::OP_TICK) begin
          if (cnt_r != '0) begin
            state_nxt = S_WRD;
          end
        end else if (bad_r) begin
          status_nxt = pte_pkg::ST_NODE;
        end else if (!p3_r) begin
          case (op_r)
            pte_pkg::OP_SET: begin
              cmd.prop_we = 1'b1;
              cmd.pw      = pte_pkg::PW_INPUT;
            end
            pte_pkg::OP_READ: begin
              cmd.prop_re = 1'b1;
              state_nxt   = S_RDAT;
            end
            default: begin
              cmd.prop_re = 1'b1;
              state_nxt   = S_FROM;
            end
          endcase
        end
      end
      S_RDAT: begin
        cmd.cap_rd = 1'b1;
        state_nxt  = S_DONE;
      end
      S_FROM: begin
        cmd.cap_from = 1'b1;
        state_nxt    = (cnt_r == '0) ? S_APPEND : S_WRD;
      end
      S_WRD: begin
        cmd.tw_re = 1'b1;
        state_nxt = S_WEV;
      end
      S_WEV: begin
        if (op_r == pte_pkg::OP_TICK && !stat.done) begin
          cmd.load_cur = 1'b1;
          dcnt_nxt     = 4'd0;
          state_nxt    = S_DIV;
        end else begin
          if (op_r == pte_pkg::OP_TICK) begin
            cmd.prop_we = 1'b1;
            cmd.pw      = pte_pkg::PW_TARGET;
          end else if (!found_r && stat.match) begin
            found_nxt = 1'b1;
          end else begin
            cmd.tw_we = 1'b1;
            cmd.tws   = pte_pkg::TW_KEEP;
            kept_nxt  = kept_r + CW'(1);
          end
          i_nxt = i_r + CW'(1);
          if (more) begin
            state_nxt = S_WRD;
          end else if (op_r == pte_pkg::OP_TICK) begin
            cnt_nxt   = kept_nxt;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_APPEND;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + 4'd1;
        if (dcnt_r == 4'd15) begin
          state_nxt = S_MX;
        end
      end
      S_MX: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_MSQ;
      end
      S_MSQ: begin
        cmd.mul_sq = 1'b1;
        state_nxt  = S_MCB;
      end
      S_MCB: begin
        cmd.mul_cb = 1'b1;
        state_nxt  = S_ME;
      end
      S_ME: begin
        cmd.mul_e = 1'b1;
        state_nxt = S_MP;
      end
      S_MP: begin
        cmd.mul_p = 1'b1;
        state_nxt = S_WWR;
      end
      S_WWR: begin
        cmd.prop_we = 1'b1;
        cmd.pw      = pte_pkg::PW_BLEND;
        cmd.tw_we   = 1'b1;
        cmd.tws     = pte_pkg::TW_UPD;
        kept_nxt    = kept_r + CW'(1);
        i_nxt       = i_r + CW'(1);
        if (more) begin
          state_nxt = S_WRD;
        end else begin
          cnt_nxt   = kept_nxt;
          state_nxt = S_DONE;
        end
      end
      S_APPEND: begin
        state_nxt = S_DONE;
        if (kept_r == CW'(TWEEN_SLOTS)) begin
          status_nxt = pte_pkg::ST_FULL;
        end else begin
          cmd.tw_we = 1'b1;
          cmd.tws   = pte_pkg::TW_NEW;
          cnt_nxt   = kept_r + CW'(1);
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign clr_addr          = clr_r;
  assign tw_raddr          = i_r[TI-1:0];
  assign tw_waddr          = kept_r[TI-1:0];
  assign busy              = state_r != S_IDLE;
  assign out_valid         = state_r == S_DONE;
  assign out_status        = status_r;
  assign out_active_tweens = 5'(cnt_r);

endmodule

// ----- rtl/pte_datapath.sv -----
// Datapath of the property tween engine: stores, divider, cube and blend units.
module pte_datapath #(
  parameter int NODE_COUNT  = 256,
  parameter int TWEEN_SLOTS = 16,
  parameter int AW          = 10,
  parameter int TI          = 4
) (
  input  logic                clk,
  input  pte_pkg::cmd_t       cmd,
  input  logic [7:0]          in_node_index,
  input  logic [1:0]          in_property_select,
  input  logic signed [31:0]  in_value,
  input  logic [23:0]         in_duration_us,
  input  logic [1:0]          in_easing_mode,
  input  logic [23:0]         in_delta_us,
  input  logic [AW-1:0]       clr_addr,
  input  logic [TI-1:0]       tw_raddr,
  input  logic [TI-1:0]       tw_waddr,
  output pte_pkg::stat_t      stat,
  output logic signed [31:0]  out_read_value
);

  localparam int P  = NODE_COUNT * 3;
  localparam int SW = (AW > 10) ? AW : 10;
  localparam int TW = $bits(pte_pkg::tween_t);

  function automatic logic [AW-1:0] slot_of(input logic [7:0] n, input logic [1:0] p);
    logic [SW-1:0] s;
    s = SW'(n) + SW'({n, 1'b0}) + SW'(p);
    return s[AW-1:0];
  endfunction

  logic [7:0]  node_r;
  logic [1:0]  prop_r, curve_r;
  logic [31:0] val_r, from_r, rdv_r;
  logic [23:0] len_r, delta_r, rem_r;
  logic [AW-1:0] slot_r;

  pte_pkg::tween_t rd_ent, cur_r, new_ent, ld_ent, tw_wdata;
  logic [TW-1:0]   tw_rdata;
  logic [31:0]     prop_rdata, prop_wdata;
  logic [AW-1:0]   prop_waddr;

  logic [25:0] el_sum;
  logic [24:0] el_sat;
  logic [24:0] dsh;
  logic [15:0] q_r;
  logic [16:0] inv, x_r, e_r, cube_sh;
  logic [33:0] sq_r;
  logic [50:0] cb_r;
  logic        use_t;
  logic signed [32:0] diff;
  logic signed [50:0] prod_r;
  logic signed [34:0] qv;
  logic [31:0] blend_v;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      node_r  <= in_node_index;
      prop_r  <= in_property_select;
      val_r   <= in_value;
      len_r   <= in_duration_us;
      curve_r <= in_easing_mode;
      delta_r <= in_delta_us;
      slot_r  <= slot_of(in_node_index, in_property_select);
      rdv_r   <= 32'd0;
    end else if (cmd.cap_rd) begin
      rdv_r <= prop_rdata;
    end
    if (cmd.cap_from) begin
      from_r <= prop_rdata;
    end
  end

  assign rd_ent = pte_pkg::tween_t'(tw_rdata);
  assign el_sum = {1'b0, rd_ent.el} + 26'(delta_r);
  assign el_sat = el_sum[25] ? '1 : el_sum[24:0];
  assign stat.done  = (rd_ent.len == 24'd0) || (el_sat >= {1'b0, rd_ent.len});
  assign stat.match = (rd_ent.node == node_r) && (rd_ent.prop == prop_r);

  assign dsh     = {rem_r, 1'b0};
  assign inv     = 17'h10000 - {1'b0, q_r};
  assign use_t   = (cur_r.curve == pte_pkg::EASE_IN) ||
                   ((cur_r.curve == pte_pkg::EASE_INOUT) && !q_r[15]);
  assign cube_sh = (cur_r.curve == pte_pkg::EASE_INOUT) ? 17'(cb_r >> 30) : 17'(cb_r >> 32);
  assign diff    = $signed({cur_r.to[31], cur_r.to}) - $signed({cur_r.from[31], cur_r.from});
  assign qv      = 35'(prod_r >>> 16);
  assign blend_v = cur_r.from + qv[31:0];

  always_ff @(posedge clk) begin
    if (cmd.load_cur) begin
      cur_r    <= ld_ent;
      rem_r    <= el_sat[23:0];
      q_r      <= 16'd0;
    end else if (cmd.div_step) begin
      if (dsh >= {1'b0, cur_r.len}) begin
        rem_r <= 24'(dsh - {1'b0, cur_r.len});
        q_r   <= {q_r[14:0], 1'b1};
      end else begin
        rem_r <= dsh[23:0];
        q_r   <= {q_r[14:0], 1'b0};
      end
    end
    if (cmd.mul_x) begin
      x_r <= use_t ? {1'b0, q_r} : inv;
    end
    if (cmd.mul_sq) begin
      sq_r <= x_r * x_r;
    end
    if (cmd.mul_cb) begin
      cb_r <= sq_r * x_r;
    end
    if (cmd.mul_e) begin
      if (cur_r.curve == pte_pkg::EASE_LINEAR) begin
        e_r <= {1'b0, q_r};
      end else if (use_t) begin
        e_r <= cube_sh;
      end else begin
        e_r <= 17'h10000 - cube_sh;
      end
    end
    if (cmd.mul_p) begin
      prod_r <= diff * $signed({1'b0, e_r});
    end
  end

  always_comb begin
    ld_ent        = rd_ent;
    ld_ent.el     = el_sat;
    new_ent.node  = node_r;
    new_ent.prop  = prop_r;
    new_ent.from  = from_r;
    new_ent.to    = val_r;
    new_ent.len   = len_r;
    new_ent.el    = 25'd0;
    new_ent.curve = curve_r;
    case (cmd.tws)
      pte_pkg::TW_UPD: tw_wdata = cur_r;
      pte_pkg::TW_NEW: tw_wdata = new_ent;
      default:         tw_wdata = rd_ent;
    endcase
  end

  always_comb begin
    unique case (cmd.pw)
      pte_pkg::PW_CLEAR: begin
        prop_waddr = clr_addr;
        prop_wdata = cmd.clr_one ? pte_pkg::Q_ONE : 32'd0;
      end
      pte_pkg::PW_INPUT: begin
        prop_waddr = slot_r;
        prop_wdata = val_r;
      end
      pte_pkg::PW_TARGET: begin
        prop_waddr = slot_of(rd_ent.node, rd_ent.prop);
        prop_wdata = rd_ent.to;
      end
      default: begin
        prop_waddr = slot_of(cur_r.node, cur_r.prop);
        prop_wdata = blend_v;
      end
    endcase
  end

  pte_ram #(.W(32), .D(P)) u_prop_ram (
    .clk   (clk),
    .we    (cmd.prop_we),
    .waddr (prop_waddr),
    .wdata (prop_wdata),
    .re    (cmd.prop_re),
    .raddr (slot_r),
    .rdata (prop_rdata)
  );

  pte_ram #(.W(TW), .D(TWEEN_SLOTS)) u_tween_ram (
    .clk   (clk),
    .we    (cmd.tw_we),
    .waddr (tw_waddr),
    .wdata (tw_wdata),
    .re    (cmd.tw_re),
    .raddr (tw_raddr),
    .rdata (tw_rdata)
  );

  assign out_read_value = rdv_r;

endmodule

// ----- rtl/property_tween_engine.sv -----
// Top level of the property tween engine: controller plus datapath.
//
// Channel  Ports                               Handshake
// input    in_opcode .. in_delta_us            accepted when start is high and busy low
// result   out_read_value, out_status, ...     one cycle, marked by out_valid
//
// A set, or an item with a bad node or selector three, gives its result straight from
// decode; a read first reads the property store, and a start also walks the tween table.
// A tick walks the tween table: finished tweens write their target, and each running tween
// passes the 16-step divider and the cube and blend multipliers. Busy falls in the cycle after the result.
// After reset a clearing pass over the NODE_COUNT*3 slots initialises the property store
// while busy stays high. The receiver cannot stall; each result is shown once.
module property_tween_engine #(
  parameter int NODE_COUNT  = 256,
  parameter int TWEEN_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_node_index,
  input  logic [1:0]         in_property_select,
  input  logic signed [31:0] in_value,
  input  logic [23:0]        in_duration_us,
  input  logic [1:0]         in_easing_mode,
  input  logic [23:0]        in_delta_us,
  output logic               out_valid,
  output logic signed [31:0] out_read_value,
  output logic [1:0]         out_status,
  output logic [4:0]         out_active_tweens
);

  localparam int P  = NODE_COUNT * 3;
  localparam int AW = (P > 1) ? $clog2(P) : 1;
  localparam int TI = (TWEEN_SLOTS > 1) ? $clog2(TWEEN_SLOTS) : 1;
  localparam int CW = $clog2(TWEEN_SLOTS + 1);

  pte_pkg::cmd_t  cmd;
  pte_pkg::stat_t stat;
  logic [AW-1:0]  clr_addr;
  logic [TI-1:0]  tw_raddr, tw_waddr;

  pte_ctrl #(
    .NODE_COUNT  (NODE_COUNT),
    .TWEEN_SLOTS (TWEEN_SLOTS),
    .AW          (AW),
    .TI          (TI),
    .CW          (CW)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .in_opcode          (in_opcode),
    .in_node_index      (in_node_index),
    .in_property_select (in_property_select),
    .stat               (stat),
    .cmd                (cmd),
    .clr_addr           (clr_addr),
    .tw_raddr           (tw_raddr),
    .tw_waddr           (tw_waddr),
    .busy               (busy),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_active_tweens  (out_active_tweens)
  );

  pte_datapath #(
    .NODE_COUNT  (NODE_COUNT),
    .TWEEN_SLOTS (TWEEN_SLOTS),
    .AW          (AW),
    .TI          (TI)
  ) u_datapath (
    .clk                (clk),
    .cmd                (cmd),
    .in_node_index      (in_node_index),
    .in_property_select (in_property_select),
    .in_value           (in_value),
    .in_duration_us     (in_duration_us),
    .in_easing_mode     (in_easing_mode),
    .in_delta_us        (in_delta_us),
    .clr_addr           (clr_addr),
    .tw_raddr           (tw_raddr),
    .tw_waddr           (tw_waddr),
    .stat               (stat),
    .out_read_value     (out_read_value)
  );

endmodule

// ----- verif/property_tween_engine_test.sv -----
// Self-checking testbench of the property tween engine with its own tween predictor.
module property_tween_engine_test;

  localparam logic [1:0] CURVE_OUT = 2'd2;
  localparam int NODES = 256;
  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  node;
    logic [1:0]  prop;
    logic [31:0] value;
    logic [23:0] dur;
    logic [1:0]  curve;
    logic [23:0] delta;
    bit          drain;
  } cmd_item_t;

  typedef struct {
    logic [31:0] rd;
    logic [1:0]  status;
    logic [4:0]  count;
  } outcome_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_opcode = '0;
  logic [7:0] in_node_index = '0;
  logic [1:0] in_property_select = '0;
  logic signed [31:0] in_value = '0;
  logic [23:0] in_duration_us = '0;
  logic [1:0] in_easing_mode = '0;
  logic [23:0] in_delta_us = '0;
  logic out_valid;
  logic signed [31:0] out_read_value;
  logic [1:0] out_status;
  logic [4:0] out_active_tweens;

  property_tween_engine dut (.*);

  initial forever #5 clk = ~clk;

  // Predicted engine state.
  logic [31:0] prop_mem [NODES*3];
  logic [7:0]  tw_node [SLOTS];
  logic [1:0]  tw_prop [SLOTS];
  logic [31:0] tw_from [SLOTS];
  logic [31:0] tw_to [SLOTS];
  logic [23:0] tw_len [SLOTS];
  logic [24:0] tw_el [SLOTS];
  logic [1:0]  tw_curve [SLOTS];
  int tw_count;

  cmd_item_t pending_items[$];
  outcome_t  expected_outcomes[$];
  int accepted_count = 0;
  int issued_count = 0;
  int gap = 0;
  int errors = 0;
  int results_seen = 0;
  int ticks_sent = 0;
  int starts_sent = 0;
  longint cycles = 0;
  bit burst = 0;

  function automatic longint cube(longint x);
    return (x * x * x) >>> 32;
  endfunction

  function automatic longint ease(logic [1:0] curve, longint t);
    longint inv;
    inv = 65536 - t;
    case (curve)
      pte_pkg::EASE_IN: return cube(t);
      CURVE_OUT: return 65536 - cube(inv);
      pte_pkg::EASE_INOUT: return (t < 32768) ? ((t * t * t * 4) >>> 32)
                                              : 65536 - ((inv * inv * inv * 4) >>> 32);
      default: return t;
    endcase
  endfunction

  function automatic logic [31:0] blend(logic [31:0] from, logic [31:0] to, longint e);
    longint f;
    longint d;
    f = longint'($signed(from));
    d = longint'($signed(to)) - f;
    return 32'(f + ((d * e) >>> 16));
  endfunction

  function automatic void advance_tweens(logic [23:0] delta);
    int kept;
    int slot;
    longint el;
    longint t;
    kept = 0;
    for (int i = 0; i < tw_count; i++) begin
      slot = tw_node[i] * 3 + tw_prop[i];
      el = longint'(tw_el[i]) + delta;
      if (el > 33554431) el = 33554431;
      tw_el[i] = 25'(el);
      if (tw_len[i] == 0 || el >= tw_len[i]) begin
        prop_mem[slot] = tw_to[i];
      end else begin
        t = (el << 16) / tw_len[i];
        prop_mem[slot] = blend(tw_from[i], tw_to[i], ease(tw_curve[i], t));
        tw_node[kept] = tw_node[i];
        tw_prop[kept] = tw_prop[i];
        tw_from[kept] = tw_from[i];
        tw_to[kept] = tw_to[i];
        tw_len[kept] = tw_len[i];
        tw_el[kept] = tw_el[i];
        tw_curve[kept] = tw_curve[i];
        kept++;
      end
    end
    tw_count = kept;
  endfunction

  function automatic outcome_t predict_engine(cmd_item_t c);
    outcome_t r;
    int slot;
    r.rd = '0;
    r.status = pte_pkg::ST_OK;
    if (c.op == pte_pkg::OP_TICK) begin
      advance_tweens(c.delta);
    end else if (c.prop != pte_pkg::PROP_NONE) begin
      slot = c.node * 3 + c.prop;
      if (c.op == pte_pkg::OP_SET) begin
        prop_mem[slot] = c.value;
      end else if (c.op == pte_pkg::OP_READ) begin
        r.rd = prop_mem[slot];
      end else begin
        for (int k = 0; k < tw_count; k++) begin
          if (tw_node[k] == c.node && tw_prop[k] == c.prop) begin
            for (int j = k; j + 1 < tw_count; j++) begin
              tw_node[j] = tw_node[j+1];
              tw_prop[j] = tw_prop[j+1];
              tw_from[j] = tw_from[j+1];
              tw_to[j] = tw_to[j+1];
              tw_len[j] = tw_len[j+1];
              tw_el[j] = tw_el[j+1];
              tw_curve[j] = tw_curve[j+1];
            end
            tw_count--;
            break;
          end
        end
        if (tw_count >= SLOTS) begin
          r.status = pte_pkg::ST_FULL;
        end else begin
          tw_node[tw_count] = c.node;
          tw_prop[tw_count] = c.prop;
          tw_from[tw_count] = prop_mem[slot];
          tw_to[tw_count] = c.value;
          tw_len[tw_count] = c.dur;
          tw_el[tw_count] = '0;
          tw_curve[tw_count] = c.curve;
          tw_count++;
        end
      end
    end
    r.count = 5'(tw_count);
    return r;
  endfunction

  task automatic queue_item(logic [1:0] op, logic [7:0] node, logic [1:0] prop,
                            logic [31:0] value, logic [23:0] dur, logic [1:0] curve,
                            logic [23:0] delta, bit drain = 0);
    cmd_item_t c;
    c.op = op;
    c.node = node;
    c.prop = prop;
    c.value = value;
    c.dur = dur;
    c.curve = curve;
    c.delta = delta;
    c.drain = drain;
    pending_items.insert(pending_items.size(), c);
  endtask

  task automatic queue_random_item();
    int kind;
    logic [7:0] node;
    logic [23:0] span;
    kind = $urandom_range(0, 99);
    node = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
    span = ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000));
    if (kind < 35) begin
      queue_item(pte_pkg::OP_START, node, 2'($urandom_range(0, 3)), $urandom, span,
                 2'($urandom), 24'($urandom));
    end else if (kind < 60) begin
      queue_item(pte_pkg::OP_TICK, 8'($urandom), 2'($urandom), $urandom, 24'($urandom),
                 2'($urandom), ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                                         : 24'($urandom_range(0, 1500)));
    end else if (kind < 85) begin
      queue_item(pte_pkg::OP_READ, node, 2'($urandom_range(0, 3)), $urandom, 24'($urandom),
                 2'($urandom), 24'($urandom));
    end else begin
      queue_item(pte_pkg::OP_SET, node, 2'($urandom_range(0, 3)), $urandom, 24'($urandom),
                 2'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    for (int n = 0; n < NODES; n++) begin
      prop_mem[n*3] = pte_pkg::Q_ONE;
      prop_mem[n*3+1] = '0;
      prop_mem[n*3+2] = '0;
    end
    tw_count = 0;

    // Directed part: reset values, extremes, selector three, every easing,
    // zero duration, a full table and a replacement.
    queue_item(pte_pkg::OP_READ, 8'd0, 2'd0, '0, '0, '0, '0);
    queue_item(pte_pkg::OP_READ, 8'd255, 2'd2, '0, '0, '0, '0);
    queue_item(pte_pkg::OP_SET, 8'd255, 2'd1, 32'h8000_0000, '0, '0, '0);
    queue_item(pte_pkg::OP_SET, 8'd1, pte_pkg::PROP_NONE, 32'h7FFF_FFFF, '0, '0, '0);
    queue_item(pte_pkg::OP_READ, 8'd1, pte_pkg::PROP_NONE, '0, '0, '0, '0);
    queue_item(pte_pkg::OP_START, 8'd1, pte_pkg::PROP_NONE, 32'h1234, 24'd10,
               pte_pkg::EASE_LINEAR, '0);
    queue_item(pte_pkg::OP_START, 8'd255, 2'd1, 32'h7FFF_FFFF, 24'hFFFFFF,
               pte_pkg::EASE_LINEAR, '0);
    queue_item(pte_pkg::OP_START, 8'd2, 2'd0, 32'hFFF0_0000, 24'd1000, pte_pkg::EASE_IN, '0);
    queue_item(pte_pkg::OP_START, 8'd3, 2'd1, 32'h0050_0000, 24'd1000, CURVE_OUT, '0);
    queue_item(pte_pkg::OP_START, 8'd4, 2'd2, 32'h8000_0000, 24'd1000,
               pte_pkg::EASE_INOUT, '0);
    queue_item(pte_pkg::OP_START, 8'd5, 2'd0, 32'h0003_0000, 24'd0, pte_pkg::EASE_INOUT, '0);
    queue_item(pte_pkg::OP_TICK, 8'd0, 2'd0, '0, '0, '0, 24'd300);
    queue_item(pte_pkg::OP_TICK, 8'd0, 2'd0, '0, '0, '0, 24'd400);
    queue_item(pte_pkg::OP_READ, 8'd4, 2'd2, '0, '0, '0, '0);
    queue_item(pte_pkg::OP_READ, 8'd255, 2'd1, '0, '0, '0, '0);
    for (int n = 0; n < 13; n++)
      queue_item(pte_pkg::OP_START, 8'(100 + n), 2'(n % 3), $urandom, 24'd5000, 2'(n), '0);
    queue_item(pte_pkg::OP_START, 8'd200, 2'd0, 32'h1, 24'd5, pte_pkg::EASE_IN, '0);
    queue_item(pte_pkg::OP_START, 8'd100, 2'd0, 32'h2, 24'd5, CURVE_OUT, '0);
    queue_item(pte_pkg::OP_TICK, 8'd0, 2'd0, '0, '0, '0, 24'hFFFFFF);

    for (int i = 0; i < 1150; i++) begin
      if (i == 600)
        queue_item(pte_pkg::OP_TICK, 8'd0, 2'd0, '0, '0, '0, 24'hFFFFFF, 1);
      queue_random_item();
    end

    repeat (10) @(negedge clk);
    rst_n <= 1;
  end

  // Driver: inputs move at the falling edge only.
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && accepted_count != issued_count) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 0;
      end else if (pending_items.size() > 0 &&
                   !(pending_items[0].drain && expected_outcomes.size() > 0)) begin
        in_opcode <= pending_items[0].op;
        in_node_index <= pending_items[0].node;
        in_property_select <= pending_items[0].prop;
        in_value <= pending_items[0].value;
        in_duration_us <= pending_items[0].dur;
        in_easing_mode <= pending_items[0].curve;
        in_delta_us <= pending_items[0].delta;
        void'(pending_items.pop_front());
        issued_count <= issued_count + 1;
        start <= 1;
        if ($urandom_range(0, 49) == 0) burst = ~burst;
        if (burst) gap <= 0;
        else if ($urandom_range(0, 9) == 0) gap <= $urandom_range(20, 80);
        else gap <= $urandom_range(0, 3);
      end else begin
        start <= 0;
      end
    end
  end

  // Monitor: results are checked before the item accepted at this edge is predicted.
  always @(posedge clk) begin
    outcome_t want;
    cmd_item_t c;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (expected_outcomes.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        want = expected_outcomes.pop_front();
        if (out_read_value !== want.rd) begin
          $error("read_value expected %h actual %h", want.rd, out_read_value);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_status);
          errors++;
        end
        if (out_active_tweens !== want.count) begin
          $error("active_tweens expected %0d actual %0d", want.count, out_active_tweens);
          errors++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      c.op = in_opcode;
      c.node = in_node_index;
      c.prop = in_property_select;
      c.value = in_value;
      c.dur = in_duration_us;
      c.curve = in_easing_mode;
      c.delta = in_delta_us;
      c.drain = 0;
      if (c.op == pte_pkg::OP_TICK) ticks_sent++;
      if (c.op == pte_pkg::OP_START) starts_sent++;
      expected_outcomes.insert(expected_outcomes.size(), predict_engine(c));
      accepted_count <= accepted_count + 1;
    end
  end

  initial begin
    wait (rst_n);
    wait (pending_items.size() == 0 && accepted_count == issued_count &&
          expected_outcomes.size() == 0);
    repeat (1000) @(posedge clk);
    if (expected_outcomes.size() != 0) errors++;
    $display("Items accepted: %0d, of which %0d ticks and %0d tween starts.",
             accepted_count, ticks_sent, starts_sent);
    $display("Results checked: %0d, mismatches: %0d.", results_seen, errors);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit.");
      $display("FAIL");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
rtl/pte_pkg.sv
rtl/pte_ram.sv
rtl/pte_ctrl.sv
rtl/pte_datapath.sv
rtl/property_tween_engine.sv
verif/property_tween_engine_test.sv
